@@ hdl/ubd_pkg.sv @@
// Package for the duration unit breakdown block: unit codes, unit lengths,
// register codes and the structs that travel between the cells.
// No dependencies.
package ubd_pkg;

  localparam int unsigned NUM_UNITS      = 6;
  localparam int unsigned UNIT_W         = 3;
  localparam int unsigned CNT_W          = 64;
  // Largest remainder is one year minus one second, below 2^25.
  localparam int unsigned REM_W          = 25;
  localparam int unsigned DIGITS_PER_CYC = 7;
  localparam int unsigned STEP_CYCLES    = 5;
  // Radix-4 long division: 2 bits per digit, dividend padded to a whole
  // number of digits over all step cycles.
  localparam int unsigned PAD_W          = 2 * DIGITS_PER_CYC * STEP_CYCLES;
  localparam int unsigned PHASE_W        = 3;
  localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(STEP_CYCLES);

  localparam int unsigned DATA_W         = 32;
  localparam int unsigned PADDR_W        = 3;
  localparam int unsigned EN_W           = 6;
  localparam int unsigned ZM_W           = 2;
  localparam logic [EN_W-1:0] UNIT_ENABLE_RST = 6'h3F;
  localparam logic [ZM_W-1:0] ZERO_MODE_RST   = 2'd0;

  typedef enum logic [UNIT_W-1:0] {
    UNIT_SEC,
    UNIT_MIN,
    UNIT_HOUR,
    UNIT_DAY,
    UNIT_WEEK,
    UNIT_YEAR
  } ubd_unit_t;

  typedef enum logic {
    REG_UNIT_ENABLE,
    REG_ZERO_MODE
  } ubd_reg_t;

  typedef struct packed {
    logic [EN_W-1:0] unit_enable;
    logic [ZM_W-1:0] zero_mode;
  } ubd_cfg_t;

  typedef struct packed {
    logic en;
    logic smallest;
    logic all_zeros;
    logic inter_zeros;
  } ubd_cell_cfg_t;

  typedef struct packed {
    logic step;
    logic shift;
  } ubd_ctrl_t;

  // One duration on its way down the chain.
  typedef struct packed {
    logic                            valid;
    logic [CNT_W-1:0]                rest;
    logic                            emitted;
    logic [NUM_UNITS-1:0]            emit;
    logic [NUM_UNITS-1:0][CNT_W-1:0] cnt;
  } ubd_tok_t;

  function automatic logic [REM_W-1:0] unit_len(ubd_unit_t u);
    logic [REM_W-1:0] len;
    unique case (u)
      UNIT_SEC:  len = REM_W'(1);
      UNIT_MIN:  len = REM_W'(60);
      UNIT_HOUR: len = REM_W'(3600);
      UNIT_DAY:  len = REM_W'(86400);
      UNIT_WEEK: len = REM_W'(604800);
      UNIT_YEAR: len = REM_W'(31556952);
      default:   len = REM_W'(1);
    endcase
    return len;
  endfunction

endpackage

@@ hdl/duration_unit_breakdown.sv @@
// Duration unit breakdown: splits a 64-bit duration in seconds into years,
// weeks, days, hours, minutes and seconds. Depends on ubd_pkg, ubd_regs,
// ubd_cell and ubd_emit.
//
// Input channel (in_valid/in_ready) takes one duration per beat. Result
// channel (out_valid/out_ready) gives one beat per emitted unit, largest
// unit first, with out_last_of_run on the final beat of a duration; a
// duration with nothing to emit gives no beat. unit_enable and zero_mode sit
// at byte addresses 0 and 4 of the APB-style port, pready always high.
// Six cells, one per unit, form a chain that advances at each handoff: each
// enabled cell runs a radix-4 long division (7 digits per cycle) and then
// hands off. A new duration enters at each handoff while earlier ones are
// still in later cells; in_ready pulses on the handoff cycle.
// Reset empties the chain and the output side and loads unit_enable = 63,
// zero_mode = 0. When the receiver stalls, the serializer and its collect
// register hold; once both are full, the chain freezes at the handoff and
// in_ready stays low.
module duration_unit_breakdown (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ubd_pkg::CNT_W-1:0]   in_duration_seconds,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ubd_pkg::UNIT_W-1:0]  out_unit_code,
  output logic [ubd_pkg::CNT_W-1:0]   out_unit_count,
  output logic                        out_last_of_run,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ubd_pkg::PADDR_W-1:0] paddr,
  input  logic [ubd_pkg::DATA_W-1:0]  pwdata,
  output logic [ubd_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import ubd_pkg::*;

  ubd_cfg_t                     cfg;
  ubd_cell_cfg_t                cell_cfg [NUM_UNITS];
  ubd_tok_t                     link [NUM_UNITS+1];
  ubd_ctrl_t                    ctrl;
  logic [EN_W-1:0]              smallest;
  logic [PHASE_W-1:0]           phase_r, phase_nxt;
  logic                         shift;
  logic                         emit_free;

  ubd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Lowest enabled unit.
  assign smallest = cfg.unit_enable & (~cfg.unit_enable + EN_W'(1));

  // Handoff only when the tail can leave the chain.
  assign shift      = (phase_r == PHASE_LAST) && (!link[0].valid || emit_free);
  assign in_ready   = shift;
  assign ctrl.shift = shift;
  assign ctrl.step  = phase_r != PHASE_LAST;

  always_comb begin
    phase_nxt = phase_r;
    if (phase_r != PHASE_LAST) begin
      phase_nxt = phase_r + PHASE_W'(1);
    end else if (shift) begin
      phase_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PHASE_LAST;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_comb begin
    link[NUM_UNITS].valid   = in_valid;
    link[NUM_UNITS].rest    = in_duration_seconds;
    link[NUM_UNITS].emitted = 1'b0;
    link[NUM_UNITS].emit    = '0;
    link[NUM_UNITS].cnt     = '0;
  end

  for (genvar u = 0; u < NUM_UNITS; u++) begin : g_cell
    assign cell_cfg[u].en          = cfg.unit_enable[u];
    assign cell_cfg[u].smallest    = smallest[u];
    assign cell_cfg[u].all_zeros   = cfg.zero_mode[1];
    assign cell_cfg[u].inter_zeros = cfg.zero_mode != '0;

    ubd_cell #(
      .UNIT (ubd_unit_t'(UNIT_W'(u)))
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .cfg     (cell_cfg[u]),
      .tok_in  (link[u+1]),
      .tok_out (link[u])
    );
  end

  ubd_emit u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .take            (shift),
    .tok             (link[0]),
    .free            (emit_free),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_unit_code   (out_unit_code),
    .out_unit_count  (out_unit_count),
    .out_last_of_run (out_last_of_run)
  );

  a_accept_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready
                             ##1 !in_ready)
    else $error("durations accepted closer than one chain period");

endmodule

@@ hdl/ubd_regs.sv @@
// Configuration registers (unit enable mask, zero mode) behind an APB-style port.
// Depends on ubd_pkg.
module ubd_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ubd_pkg::PADDR_W-1:0] paddr,
  input  logic [ubd_pkg::DATA_W-1:0]  pwdata,
  output logic [ubd_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output ubd_pkg::ubd_cfg_t           cfg
);
  import ubd_pkg::*;

  logic [EN_W-1:0] unit_enable_r, unit_enable_nxt;
  logic [ZM_W-1:0] zero_mode_r, zero_mode_nxt;
  ubd_reg_t        idx;
  logic            wr;

  assign idx    = ubd_reg_t'(paddr[2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    unit_enable_nxt = unit_enable_r;
    zero_mode_nxt   = zero_mode_r;
    if (wr) begin
      unique case (idx)
        REG_UNIT_ENABLE: unit_enable_nxt = pwdata[EN_W-1:0];
        REG_ZERO_MODE:   zero_mode_nxt   = pwdata[ZM_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_enable_r <= UNIT_ENABLE_RST;
      zero_mode_r   <= ZERO_MODE_RST;
    end else begin
      unit_enable_r <= unit_enable_nxt;
      zero_mode_r   <= zero_mode_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      REG_UNIT_ENABLE: prdata = DATA_W'(unit_enable_r);
      REG_ZERO_MODE:   prdata = DATA_W'(zero_mode_r);
    endcase
  end

  assign cfg.unit_enable = unit_enable_r;
  assign cfg.zero_mode   = zero_mode_r;

endmodule

@@ hdl/ubd_cell.sv @@
// One unit cell of the chain: radix-4 long division of the remaining duration
// by this unit's length, then hand the quotient and remainder to the next cell.
// Depends on ubd_pkg.
module ubd_cell #(
  parameter ubd_pkg::ubd_unit_t UNIT = ubd_pkg::UNIT_SEC
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ubd_pkg::ubd_ctrl_t     ctrl,
  input  ubd_pkg::ubd_cell_cfg_t cfg,
  input  ubd_pkg::ubd_tok_t      tok_in,
  output ubd_pkg::ubd_tok_t      tok_out
);
  import ubd_pkg::*;

  localparam int unsigned        IDX  = int'(UNIT);
  localparam logic [REM_W-1:0]   LEN  = unit_len(UNIT);
  localparam logic [REM_W+1:0]   LEN1 = {2'b00, LEN};
  localparam logic [REM_W+1:0]   LEN2 = {1'b0, LEN, 1'b0};
  localparam logic [REM_W+1:0]   LEN3 = LEN1 + LEN2;

  logic                            valid_r, valid_nxt;
  logic [PAD_W-1:0]                q_r, q_nxt;
  logic [REM_W-1:0]                rem_r, rem_nxt;
  logic                            emitted_r, emitted_nxt;
  logic [NUM_UNITS-1:0]            emit_r, emit_nxt;
  logic [NUM_UNITS-1:0][CNT_W-1:0] cnt_r, cnt_nxt;

  logic [PAD_W-1:0] q_step;
  logic [REM_W-1:0] rem_step;
  logic [CNT_W-1:0] count;
  logic             emit_here;

  // Seven radix-4 digits per cycle: shift two dividend bits into the
  // remainder, subtract the largest multiple that fits, shift the digit in.
  always_comb begin
    logic [PAD_W-1:0] q;
    logic [REM_W-1:0] r;
    logic [REM_W+1:0] t;
    q = q_r;
    r = rem_r;
    for (int i = 0; i < DIGITS_PER_CYC; i++) begin
      t = {r, q[PAD_W-1 -: 2]};
      q = {q[PAD_W-3:0], 2'b00};
      priority if (t >= LEN3) begin
        r       = REM_W'(t - LEN3);
        q[1:0]  = 2'd3;
      end else if (t >= LEN2) begin
        r       = REM_W'(t - LEN2);
        q[1:0]  = 2'd2;
      end else if (t >= LEN1) begin
        r       = REM_W'(t - LEN1);
        q[1:0]  = 2'd1;
      end else begin
        r       = REM_W'(t);
      end
    end
    q_step   = q;
    rem_step = r;
  end

  always_comb begin
    valid_nxt   = valid_r;
    q_nxt       = q_r;
    rem_nxt     = rem_r;
    emitted_nxt = emitted_r;
    emit_nxt    = emit_r;
    cnt_nxt     = cnt_r;
    if (ctrl.shift) begin
      valid_nxt   = tok_in.valid;
      q_nxt       = PAD_W'(tok_in.rest);
      rem_nxt     = '0;
      emitted_nxt = tok_in.emitted;
      emit_nxt    = tok_in.emit;
      cnt_nxt     = tok_in.cnt;
    end else if (ctrl.step && cfg.en) begin
      q_nxt   = q_step;
      rem_nxt = rem_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r       <= q_nxt;
    rem_r     <= rem_nxt;
    emitted_r <= emitted_nxt;
    emit_r    <= emit_nxt;
    cnt_r     <= cnt_nxt;
  end

  // A disabled cell holds its dividend untouched and passes it on as is.
  assign count     = q_r[CNT_W-1:0];
  assign emit_here = cfg.en && (count != '0 || cfg.all_zeros ||
                     (cfg.inter_zeros && (emitted_r || cfg.smallest)));

  always_comb begin
    tok_out.valid   = valid_r;
    tok_out.rest    = cfg.en ? CNT_W'(rem_r) : count;
    tok_out.emitted = emitted_r || emit_here;
    for (int j = 0; j < NUM_UNITS; j++) begin
      if (j > IDX) begin
        tok_out.emit[j] = emit_r[j];
        tok_out.cnt[j]  = cnt_r[j];
      end else if (j == IDX) begin
        tok_out.emit[j] = emit_here;
        tok_out.cnt[j]  = count;
      end else begin
        tok_out.emit[j] = 1'b0;
        tok_out.cnt[j]  = '0;
      end
    end
  end

  a_rem_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> rem_r < LEN)
    else $error("remainder not below unit length");

  a_quot_fits: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !ctrl.step |-> q_r[PAD_W-1:CNT_W] == '0)
    else $error("quotient overflows count width at handoff");

endmodule

@@ hdl/ubd_emit.sv @@
// Result side: a collect register that takes finished durations off the chain,
// and a serializer that sends one beat per emitted unit, largest unit first.
// Depends on ubd_pkg.
module ubd_emit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       take,
  input  ubd_pkg::ubd_tok_t          tok,
  output logic                       free,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ubd_pkg::UNIT_W-1:0] out_unit_code,
  output logic [ubd_pkg::CNT_W-1:0]  out_unit_count,
  output logic                       out_last_of_run
);
  import ubd_pkg::*;

  logic                            full_a_r, full_a_nxt;
  logic [NUM_UNITS-1:0]            mask_a_r;
  logic [NUM_UNITS-1:0][CNT_W-1:0] cnt_a_r;
  logic [NUM_UNITS-1:0]            mask_b_r, mask_b_nxt;
  logic [NUM_UNITS-1:0][CNT_W-1:0] cnt_b_r, cnt_b_nxt;

  logic                 load_a;
  logic                 fire;
  logic                 move;
  logic [UNIT_W-1:0]    hi;
  logic [NUM_UNITS-1:0] hi_oh;
  logic [NUM_UNITS-1:0] mask_left;

  // Drop durations that produce no beat at all.
  assign load_a = take && tok.valid && (tok.emit != '0);
  assign free   = !full_a_r;

  always_comb begin
    hi = '0;
    for (int i = 0; i < NUM_UNITS; i++) begin
      if (mask_b_r[i]) begin
        hi = UNIT_W'(i);
      end
    end
  end

  assign hi_oh           = NUM_UNITS'(1) << hi;
  assign mask_left       = mask_b_r & ~hi_oh;
  assign out_valid       = mask_b_r != '0;
  assign out_unit_code   = hi;
  assign out_unit_count  = cnt_b_r[hi];
  assign out_last_of_run = mask_left == '0;
  assign fire            = out_valid && out_ready;
  assign move            = full_a_r && (!out_valid || (fire && out_last_of_run));

  always_comb begin
    full_a_nxt = full_a_r;
    mask_b_nxt = mask_b_r;
    cnt_b_nxt  = cnt_b_r;
    if (load_a) begin
      full_a_nxt = 1'b1;
    end else if (move) begin
      full_a_nxt = 1'b0;
    end
    if (move) begin
      mask_b_nxt = mask_a_r;
      cnt_b_nxt  = cnt_a_r;
    end else if (fire) begin
      mask_b_nxt = mask_left;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_a_r <= 1'b0;
      mask_b_r <= '0;
    end else begin
      full_a_r <= full_a_nxt;
      mask_b_r <= mask_b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_a) begin
      mask_a_r <= tok.emit;
      cnt_a_r  <= tok.cnt;
    end
    cnt_b_r <= cnt_b_nxt;
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_a |-> !full_a_r)
    else $error("collect register overwritten while full");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !out_last_of_run |=> out_valid)
    else $error("run ended without a last beat");

endmodule

@@ tb/tb_duration_unit_breakdown.sv @@
// Self-checking bench for duration_unit_breakdown: drives durations and
// register writes, predicts the unit beats and compares them on the result side.
// Depends on ubd_pkg and the duration_unit_breakdown RTL.
module tb_duration_unit_breakdown;
  timeunit 1ns;
  timeprecision 1ps;
  import ubd_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 10;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 40000;
  localparam int MAX_PRINTED   = 40;
  localparam int NUM_EDGES     = 15;

  localparam logic [CNT_W-1:0] UNIT_SPAN [NUM_UNITS] = '{
    64'd1, 64'd60, 64'd3600, 64'd86400, 64'd604800, 64'd31556952
  };

  localparam logic [CNT_W-1:0] EDGE_DURATIONS [NUM_EDGES] = '{
    64'd0, 64'd1, 64'd59, 64'd60, 64'd3599, 64'd3600, 64'd86399, 64'd86400,
    64'd604799, 64'd604800, 64'd31556951, 64'd31556952,
    64'd32161811, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF
  };

  typedef enum logic [ZM_W-1:0] {
    ZM_SKIP,
    ZM_INTER,
    ZM_ALL,
    ZM_ALL_ALT
  } zero_mode_t;

  typedef struct {
    ubd_unit_t        code;
    logic [CNT_W-1:0] count;
    logic             last;
  } unit_beat_t;

  class unit_split_board;
    unit_beat_t      pending_beats[$];
    logic [EN_W-1:0] enable_mask;
    logic [ZM_W-1:0] zero_mode;
    int              errors;

    function new();
      enable_mask = UNIT_ENABLE_RST;
      zero_mode   = ZERO_MODE_RST;
      errors      = 0;
    endfunction

    task report(string msg);
      if (errors < MAX_PRINTED)
        $display("%0t mismatch: %s", $time, msg);
      errors++;
    endtask

    function void write_reg(ubd_reg_t r, logic [DATA_W-1:0] v);
      case (r)
        REG_UNIT_ENABLE: enable_mask = v[EN_W-1:0];
        REG_ZERO_MODE:   zero_mode = v[ZM_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [DATA_W-1:0] reg_value(ubd_reg_t r);
      return (r == REG_UNIT_ENABLE) ? DATA_W'(enable_mask) : DATA_W'(zero_mode);
    endfunction

    function int pending();
      return pending_beats.size();
    endfunction

    // Split one accepted duration into the beats it should produce.
    function void note_duration(logic [CNT_W-1:0] dur);
      logic [CNT_W-1:0] rest;
      logic [CNT_W-1:0] count;
      logic             emitted;
      logic             all_z;
      logic             inter_z;
      int               smallest;
      unit_beat_t       run[$];
      unit_beat_t       b;
      rest     = dur;
      all_z    = zero_mode[1];
      inter_z  = (zero_mode != ZM_SKIP);
      emitted  = 1'b0;
      smallest = -1;
      for (int u = 0; u < NUM_UNITS; u++)
        if (enable_mask[u] && smallest < 0) smallest = u;
      for (int u = NUM_UNITS - 1; u >= 0; u--) begin
        if (!enable_mask[u]) continue;
        count = rest / UNIT_SPAN[u];
        rest  = rest % UNIT_SPAN[u];
        if (count != 0 || all_z || (inter_z && (emitted || u == smallest))) begin
          b.code  = ubd_unit_t'(u);
          b.count = count;
          b.last  = 1'b0;
          run.push_back(b);
          emitted = 1'b1;
        end
      end
      if (run.size() > 0) run[run.size()-1].last = 1'b1;
      foreach (run[i]) pending_beats.push_back(run[i]);
    endfunction

    task check_beat(logic [UNIT_W-1:0] code, logic [CNT_W-1:0] count, logic last);
      unit_beat_t want;
      if (pending_beats.size() == 0) begin
        report($sformatf("beat with nothing pending: unit %0d count %0d", code, count));
        return;
      end
      want = pending_beats.pop_front();
      if (code !== want.code)
        report($sformatf("unit_code %0d, want %0d", code, want.code));
      if (count !== want.count)
        report($sformatf("unit_count %0d, want %0d (unit %0d)", count, want.count, want.code));
      if (last !== want.last)
        report($sformatf("last_of_run %0b, want %0b (unit %0d)", last, want.last, want.code));
    endtask
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [CNT_W-1:0]    in_duration_seconds;
  logic                out_valid;
  logic                out_ready;
  logic [UNIT_W-1:0]   out_unit_code;
  logic [CNT_W-1:0]    out_unit_count;
  logic                out_last_of_run;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  unit_split_board board;
  int              send_idle_pct;
  int              recv_idle_pct;
  int              hold_left;
  int              cycles;

  duration_unit_breakdown dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_duration_seconds (in_duration_seconds),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_unit_code       (out_unit_code),
    .out_unit_count      (out_unit_count),
    .out_last_of_run     (out_last_of_run),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL duration_unit_breakdown");
    $finish;
  end

  // Receiver: random stalls, or a counted hold-off when one is requested.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) board.note_duration(in_duration_seconds);
      if (out_valid && out_ready)
        board.check_beat(out_unit_code, out_unit_count, out_last_of_run);
    end
  end

  // Write a register, then read it back.
  task automatic write_register(ubd_reg_t r, logic [DATA_W-1:0] v);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = PADDR_W'(int'(r) * 4);
    pwdata  = v;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    board.write_reg(r, v);
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== board.reg_value(r))
      board.report($sformatf("register %0d reads %0h, want %0h", r, prdata,
                             board.reg_value(r)));
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic offer_duration(logic [CNT_W-1:0] dur);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid            = 1'b1;
    in_duration_seconds = dur;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid, wait for every pending beat, then let the chain empty.
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Registers change only with the chain and the result side empty.
  task automatic configure(logic [EN_W-1:0] mask, zero_mode_t mode);
    settle();
    write_register(REG_UNIT_ENABLE, DATA_W'(mask));
    write_register(REG_ZERO_MODE, DATA_W'(mode));
  endtask

  function automatic logic [CNT_W-1:0] random_duration();
    logic [CNT_W-1:0] d;
    case ($urandom_range(7))
      0: d = $urandom_range(59);
      1: d = $urandom_range(3599);
      2: d = $urandom_range(86399);
      3: d = $urandom_range(31556951);
      4: d = UNIT_SPAN[$urandom_range(NUM_UNITS-1)] * $urandom_range(1, 60);
      5: d = UNIT_SPAN[UNIT_YEAR] * $urandom_range(1, 3000) + $urandom_range(3) * 60;
      6: d = {$urandom(), $urandom()};
      default: d = {$urandom(), $urandom()} >> $urandom_range(63);
    endcase
    return d;
  endfunction

  // Offer n random durations; start a long receiver hold-off before duration hold_at.
  task automatic random_batch(int n, int hold_at);
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) hold_left = HOLD_CYCLES;
      offer_duration(random_duration());
    end
  endtask

  task automatic edge_batch();
    for (int i = 0; i < NUM_EDGES; i++) offer_duration(EDGE_DURATIONS[i]);
  endtask

  initial begin
    board               = new();
    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_duration_seconds = '0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    hold_left           = 0;
    send_idle_pct       = 34;
    recv_idle_pct       = 62;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    edge_batch();
    configure(6'h3F, ZM_INTER);
    random_batch(14, 2);
    configure(6'b101010, ZM_ALL_ALT);
    random_batch(10, -1);

    send_idle_pct = 62;
    recv_idle_pct = 34;
    configure(6'b011100, ZM_INTER);
    random_batch(10, -1);
    configure(6'b000000, ZM_ALL);
    random_batch(5, -1);
    configure(6'b100001, ZM_SKIP);
    random_batch(10, -1);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(6'h3F, ZM_ALL);
    random_batch(16, -1);
    configure(6'b010110, ZM_INTER);
    random_batch(10, -1);
    configure(6'h3F, ZM_INTER);
    edge_batch();

    settle();
    if (board.errors == 0 && board.pending() == 0)
      $display("PASS duration_unit_breakdown");
    else
      $display("FAIL duration_unit_breakdown");
    $finish;
  end
endmodule
